// ===== rtl/core/io_operation_stats_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// I/O operation statistics - assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef IO_OPERATION_STATS_ACCUMULATOR_DEFINES_SVH
`define IO_OPERATION_STATS_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define IOSA_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define IOSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define IOSA_ASSERT(lbl, clk, rst_n, cond)
`define IOSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/iosa_pkg.sv =====
// ----------------------------------------------------------------------------
// iosa_pkg
// Shared types and constants of the I/O operation statistics block.
// ----------------------------------------------------------------------------
package iosa_pkg;

    localparam int NUM_OBJECTS_DEF = 64;
    localparam int NUM_OPS_DEF     = 8;

    localparam int OBJ_W  = 6;
    localparam int OP_W   = 4;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 7;
    localparam int OUT_TDATA_W = 448;

    // one input record as it sits in the queue
    typedef struct packed {
        logic             completed;
        logic             aborted;
        logic             is_async;
        logic [CNT_W-1:0] latency;
        logic [CNT_W-1:0] done_bytes;
        logic [CNT_W-1:0] asked_bytes;
    } t_rec;

    // table entry; last member lands in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] async_total;
        logic [SUM_W-1:0] failure_bytes_sum;
        logic [CNT_W-1:0] failure_total;
        logic [CNT_W-1:0] size_mean;
        logic [CNT_W-1:0] size_max;
        logic [CNT_W-1:0] size_min;
        logic [CNT_W-1:0] latency_mean;
        logic [CNT_W-1:0] latency_max;
        logic [CNT_W-1:0] latency_min;
        logic [SUM_W-1:0] complete_bytes_sum;
        logic [CNT_W-1:0] complete_total;
        logic [CNT_W-1:0] request_total;
    } t_entry;

    // back end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

// ===== rtl/core/io_operation_stats_accumulator.sv =====
// ----------------------------------------------------------------------------
// io_operation_stats_accumulator
// Per object and operation class I/O statistics table.
// ----------------------------------------------------------------------------
// Each accepted completion record updates one table entry and returns that
// entry. The back end reads the entry, forms the mean products, runs the
// two bit-serial mean divisions side by side, then writes the entry back
// and registers it as the result; records needing no division skip the
// divisions. The 32-step divider sets the sustained rate while the output
// does not stall. Records with an object index or class out of range are
// taken and dropped. After reset a clearing pass over all
// NUM_OBJECTS*NUM_OPS entries zeroes the table; no record is taken meanwhile.
module io_operation_stats_accumulator #(
    parameter int NUM_OBJECTS = iosa_pkg::NUM_OBJECTS_DEF,
    parameter int NUM_OPS     = iosa_pkg::NUM_OPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // object_index, latency, done_bytes, asked_bytes, zero pad
    input  logic [iosa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op_class, completed, aborted, is_async
    input  logic [iosa_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // request_total, complete_total, complete_bytes_sum, latency_min,
    // latency_max, latency_mean, size_min, size_max, size_mean,
    // failure_total, failure_bytes_sum, async_total
    output logic [iosa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH = NUM_OBJECTS * NUM_OPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    iosa_pkg::t_back_stat w_stat;
    logic                 w_q_valid;
    iosa_pkg::t_rec       w_q_rec;
    logic [AW-1:0]        w_q_addr;

    iosa_front #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .NUM_OPS     (NUM_OPS),
        .AW          (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_back    (w_stat),
        .o_q_valid (w_q_valid),
        .o_q_rec   (w_q_rec),
        .o_q_addr  (w_q_addr)
    );

    iosa_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_rec   (w_q_rec),
        .i_q_addr  (w_q_addr),
        .o_stat    (w_stat),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ===== rtl/core/iosa_ram.sv =====
// ----------------------------------------------------------------------------
// iosa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module iosa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/iosa_front.sv =====
// ----------------------------------------------------------------------------
// iosa_front
// Takes records, drops out-of-range ones, forms the table address and
// holds up to two records for the back end.
// ----------------------------------------------------------------------------
module iosa_front #(
    parameter int NUM_OBJECTS = iosa_pkg::NUM_OBJECTS_DEF,
    parameter int NUM_OPS     = iosa_pkg::NUM_OPS_DEF,
    parameter int AW          = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [iosa_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic [iosa_pkg::IN_TUSER_W-1:0] i_tuser,
    input  iosa_pkg::t_back_stat            i_back,
    output logic                            o_q_valid,
    output iosa_pkg::t_rec                  o_q_rec,
    output logic [AW-1:0]                   o_q_addr
);

    logic [iosa_pkg::OBJ_W-1:0] w_obj;
    logic [iosa_pkg::OP_W-1:0]  w_op;
    logic                       w_in_range;
    logic [31:0]                w_addr_full;
    logic                       w_push;
    iosa_pkg::t_rec             w_rec;

    iosa_pkg::t_rec r_q_rec  [2];
    logic [AW-1:0]  r_q_addr [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;

    assign w_obj = i_tdata[5:0];
    assign w_op  = i_tuser[3:0];

    assign w_in_range = (32'(w_obj) < 32'(NUM_OBJECTS)) && (w_op != '0)
                        && (32'(w_op) <= 32'(NUM_OPS));
    assign w_addr_full = 32'(w_obj) * 32'(NUM_OPS) + 32'(w_op) - 32'd1;

    always_comb begin
        w_rec.completed   = i_tuser[4];
        w_rec.aborted     = i_tuser[5];
        w_rec.is_async    = i_tuser[6];
        w_rec.latency     = i_tdata[37:6];
        w_rec.done_bytes  = i_tdata[69:38];
        w_rec.asked_bytes = i_tdata[101:70];
    end

    assign o_tready = !i_back.clearing && (r_cnt != 2'd2);
    assign w_push   = i_tvalid && o_tready && w_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_q_rec[r_wr_ptr]  <= w_rec;
                r_q_addr[r_wr_ptr] <= w_addr_full[AW-1:0];
                r_wr_ptr           <= !r_wr_ptr;
            end
            if (i_back.pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_back.pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_rec   = r_q_rec[r_rd_ptr];
    assign o_q_addr  = r_q_addr[r_rd_ptr];

endmodule

// ===== rtl/core/iosa_div.sv =====
// ----------------------------------------------------------------------------
// iosa_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Quotient must fit in 32 bits (upper dividend half below divisor).
// ----------------------------------------------------------------------------
module iosa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_quo <= i_dividend[31:0];
            r_div <= i_divisor;
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_div}) : w_trial[31:0];
            r_quo <= {r_quo[30:0], w_ge};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_busy     = (r_cnt != 6'd0);
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/iosa_back.sv =====
// ----------------------------------------------------------------------------
// iosa_back
// Sequencer: read entry, update counts and extrema, run the two mean
// divisions, write back and present the entry.
// ----------------------------------------------------------------------------
`include "io_operation_stats_accumulator_defines.svh"

module iosa_back #(
    parameter int DEPTH = iosa_pkg::NUM_OBJECTS_DEF * iosa_pkg::NUM_OPS_DEF,
    parameter int AW    = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  iosa_pkg::t_rec                   i_q_rec,
    input  logic [AW-1:0]                    i_q_addr,
    output iosa_pkg::t_back_stat             o_stat,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [iosa_pkg::OUT_TDATA_W-1:0] o_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_WRITE
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic [AW-1:0]   r_addr;
    iosa_pkg::t_rec  r_rec;
    iosa_pkg::t_entry r_ent;
    iosa_pkg::t_entry r_out;
    logic            r_out_valid;
    logic            r_first;
    logic [31:0]     r_n;
    logic [63:0]     r_plat;
    logic [63:0]     r_psz;

    iosa_pkg::t_entry w_cur;
    iosa_pkg::t_entry n_ent;
    logic [31:0]     w_n;
    logic            w_out_free;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    iosa_pkg::t_entry w_wdata;
    logic [$bits(iosa_pkg::t_entry)-1:0] w_rdata;
    logic            w_div_start;
    logic            w_lat_busy;
    logic            w_sz_busy;
    logic [31:0]     w_lat_q;
    logic [31:0]     w_sz_q;
    logic            w_lat_ok;
    logic            w_sz_ok;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_we       = (r_state == S_CLEAR) || ((r_state == S_WRITE) && w_out_free);
    assign w_waddr    = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_wdata    = (r_state == S_CLEAR) ? '0 : r_ent;

    assign o_stat.pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.clearing = (r_state == S_CLEAR);

    iosa_ram #(
        .WIDTH ($bits(iosa_pkg::t_entry)),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_q_addr),
        .o_rdata (w_rdata)
    );

    // entry update from the read data, means left for the dividers
    always_comb begin
        w_cur = iosa_pkg::t_entry'(w_rdata);
        w_n   = w_cur.complete_total + 32'd1;
        n_ent = w_cur;
        n_ent.request_total = w_cur.request_total + 32'd1;
        if (r_rec.is_async) begin
            n_ent.async_total = w_cur.async_total + 32'd1;
        end
        if (r_rec.completed) begin
            n_ent.complete_total     = w_n;
            n_ent.complete_bytes_sum = w_cur.complete_bytes_sum + 64'(r_rec.done_bytes);
            if (w_n > 32'd1) begin
                if (r_rec.latency < w_cur.latency_min) n_ent.latency_min = r_rec.latency;
                if (r_rec.latency > w_cur.latency_max) n_ent.latency_max = r_rec.latency;
                if (r_rec.done_bytes < w_cur.size_min) n_ent.size_min = r_rec.done_bytes;
                if (r_rec.done_bytes > w_cur.size_max) n_ent.size_max = r_rec.done_bytes;
            end else begin
                n_ent.latency_min  = r_rec.latency;
                n_ent.latency_max  = r_rec.latency;
                n_ent.latency_mean = r_rec.latency;
                n_ent.size_min     = r_rec.done_bytes;
                n_ent.size_max     = r_rec.done_bytes;
                n_ent.size_mean    = r_rec.done_bytes;
            end
        end else if (r_rec.aborted) begin
            n_ent.failure_total     = w_cur.failure_total + 32'd1;
            n_ent.failure_bytes_sum = w_cur.failure_bytes_sum + 64'(r_rec.asked_bytes);
        end
    end

    assign w_div_start = (r_state == S_CALC) && r_rec.completed && !r_first;

    iosa_div u_div_lat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_plat + 64'(r_rec.latency)),
        .i_divisor  (r_n),
        .o_busy     (w_lat_busy),
        .o_quotient (w_lat_q)
    );

    iosa_div u_div_sz (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_psz + 64'(r_rec.done_bytes)),
        .i_divisor  (r_n),
        .o_busy     (w_sz_busy),
        .o_quotient (w_sz_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_WRITE the output register is reloaded below instead
            if (r_out_valid && i_tready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_rec   <= i_q_rec;
                        r_addr  <= i_q_addr;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_ent   <= n_ent;
                    r_n     <= w_n;
                    r_first <= (w_n <= 32'd1);
                    r_plat  <= {32'd0, w_cur.latency_mean} * {32'd0, w_n - 32'd1};
                    r_psz   <= {32'd0, w_cur.size_mean} * {32'd0, w_n - 32'd1};
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= w_div_start ? S_DIV : S_WRITE;
                end
                S_DIV: begin
                    if (!w_lat_busy && !w_sz_busy) begin
                        r_ent.latency_mean <= w_lat_q;
                        r_ent.size_mean    <= w_sz_q;
                        r_state            <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_out_free) begin
                        r_out       <= r_ent;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out;

    assign w_lat_ok = (r_ent.latency_min <= r_ent.latency_mean)
                      && (r_ent.latency_mean <= r_ent.latency_max);
    assign w_sz_ok  = (r_ent.size_min <= r_ent.size_mean)
                      && (r_ent.size_mean <= r_ent.size_max);

    `IOSA_ASSERT_IMP(a_div_idle_at_start, i_clk, i_rst_n, w_div_start, !w_lat_busy && !w_sz_busy)
    `IOSA_ASSERT_IMP(a_lat_order, i_clk, i_rst_n, r_state == S_WRITE, w_lat_ok)
    `IOSA_ASSERT_IMP(a_size_order, i_clk, i_rst_n, r_state == S_WRITE, w_sz_ok)
    `IOSA_ASSERT_IMP(a_no_pop_clearing, i_clk, i_rst_n, o_stat.clearing, !o_stat.pop)

endmodule

// ===== bench/io_operation_stats_accumulator_test.sv =====
// ----------------------------------------------------------------------------
// io_operation_stats_accumulator_test
// Sends I/O completion records through the input stream. Keeps its own copy
// of the per object and class statistics table to work out each returned
// entry, and checks every output transfer against it field by field.
// ----------------------------------------------------------------------------
module io_operation_stats_accumulator_test;
    import iosa_pkg::*;

    localparam int N_OBJ  = NUM_OBJECTS_DEF;
    localparam int N_OP   = NUM_OPS_DEF;
    localparam int DEPTH  = N_OBJ * N_OP;
    localparam int SETTLE = 60;

    // operation classes
    typedef enum logic [OP_W-1:0] {
        OP_NONE = 4'd0, OP_CREATE = 4'd1, OP_CONNECT = 4'd2, OP_ACCEPT = 4'd3,
        OP_IOCTL = 4'd4, OP_FSCTL = 4'd5, OP_READ = 4'd6, OP_WRITE = 4'd7,
        OP_CLOSE = 4'd8, OP_BAD_HI = 4'd15
    } t_op;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // object_index, latency, done_bytes, asked_bytes, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op_class, completed, aborted, is_async
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // request_total .. async_total, request_total lowest
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    io_operation_stats_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow statistics table
    logic [CNT_W-1:0] tbl_req   [DEPTH];
    logic [CNT_W-1:0] tbl_done  [DEPTH];
    logic [SUM_W-1:0] tbl_dsum  [DEPTH];
    logic [CNT_W-1:0] tbl_lmin  [DEPTH];
    logic [CNT_W-1:0] tbl_lmax  [DEPTH];
    logic [CNT_W-1:0] tbl_lmean [DEPTH];
    logic [CNT_W-1:0] tbl_smin  [DEPTH];
    logic [CNT_W-1:0] tbl_smax  [DEPTH];
    logic [CNT_W-1:0] tbl_smean [DEPTH];
    logic [CNT_W-1:0] tbl_fail  [DEPTH];
    logic [SUM_W-1:0] tbl_fsum  [DEPTH];
    logic [CNT_W-1:0] tbl_async [DEPTH];

    t_entry pending_entries[$];
    int     mismatches;
    int     reported;
    bit     ready_quiet;
    int     hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] mean_step(logic [CNT_W-1:0] mean,
                                                   logic [CNT_W-1:0] x,
                                                   logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] acc;
        acc = SUM_W'(mean) * SUM_W'(n - 1) + SUM_W'(x);
        return CNT_W'(acc / SUM_W'(n));
    endfunction

    // applies one record to the shadow table; returns 0 for a dropped record
    function automatic bit stats_update(logic [OBJ_W-1:0] obj, logic [OP_W-1:0] op,
                                        t_rec r, output t_entry res);
        int e;
        logic [CNT_W-1:0] n;
        res = '0;
        if (int'(obj) >= N_OBJ || op == OP_NONE || int'(op) > N_OP) return 0;
        e = int'(obj) * N_OP + int'(op) - 1;
        tbl_req[e]++;
        if (r.completed) begin
            tbl_dsum[e] += SUM_W'(r.done_bytes);
            tbl_done[e]++;
            n = tbl_done[e];
            if (n > 1) begin
                if (r.latency < tbl_lmin[e]) tbl_lmin[e] = r.latency;
                if (r.latency > tbl_lmax[e]) tbl_lmax[e] = r.latency;
                tbl_lmean[e] = mean_step(tbl_lmean[e], r.latency, n);
                if (r.done_bytes < tbl_smin[e]) tbl_smin[e] = r.done_bytes;
                if (r.done_bytes > tbl_smax[e]) tbl_smax[e] = r.done_bytes;
                tbl_smean[e] = mean_step(tbl_smean[e], r.done_bytes, n);
            end else begin
                // first sample, or the completed count wrapped
                tbl_lmin[e]  = r.latency;
                tbl_lmax[e]  = r.latency;
                tbl_lmean[e] = r.latency;
                tbl_smin[e]  = r.done_bytes;
                tbl_smax[e]  = r.done_bytes;
                tbl_smean[e] = r.done_bytes;
            end
        end else if (r.aborted) begin
            tbl_fsum[e] += SUM_W'(r.asked_bytes);
            tbl_fail[e]++;
        end
        if (r.is_async) tbl_async[e]++;
        res.request_total      = tbl_req[e];
        res.complete_total     = tbl_done[e];
        res.complete_bytes_sum = tbl_dsum[e];
        res.latency_min        = tbl_lmin[e];
        res.latency_max        = tbl_lmax[e];
        res.latency_mean       = tbl_lmean[e];
        res.size_min           = tbl_smin[e];
        res.size_max           = tbl_smax[e];
        res.size_mean          = tbl_smean[e];
        res.failure_total      = tbl_fail[e];
        res.failure_bytes_sum  = tbl_fsum[e];
        res.async_total        = tbl_async[e];
        return 1;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_record(logic [OBJ_W-1:0] obj, logic [OP_W-1:0] op,
                               bit done, bit abrt, bit asy, logic [CNT_W-1:0] lat,
                               logic [CNT_W-1:0] dbytes, logic [CNT_W-1:0] abytes,
                               bit use_gaps);
        t_rec   r;
        t_entry res;
        int     gap;
        r.completed   = done;
        r.aborted     = abrt;
        r.is_async    = asy;
        r.latency     = lat;
        r.done_bytes  = dbytes;
        r.asked_bytes = abytes;
        s_axis_tdata  <= {2'b00, abytes, dbytes, lat, obj};
        s_axis_tuser  <= {asy, abrt, done, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (stats_update(obj, op, r, res)) pending_entries.push_back(res);
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(string name, logic [SUM_W-1:0] exp_v,
                               logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("mismatch %s: expected %0h got %0h", name, exp_v, act_v);
            end
        end
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial begin
        t_entry act;
        t_entry exp_e;
        int     stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                act = t_entry'(m_axis_tdata);
                if (pending_entries.size() == 0) begin
                    mismatches++;
                    if (reported < 10) begin
                        reported++;
                        $display("unexpected output transfer %0h", m_axis_tdata);
                    end
                end else begin
                    exp_e = pending_entries.pop_front();
                    check_field("request_total", exp_e.request_total, act.request_total);
                    check_field("complete_total", exp_e.complete_total,
                                act.complete_total);
                    check_field("complete_bytes_sum", exp_e.complete_bytes_sum,
                                act.complete_bytes_sum);
                    check_field("latency_min", exp_e.latency_min, act.latency_min);
                    check_field("latency_max", exp_e.latency_max, act.latency_max);
                    check_field("latency_mean", exp_e.latency_mean, act.latency_mean);
                    check_field("size_min", exp_e.size_min, act.size_min);
                    check_field("size_max", exp_e.size_max, act.size_max);
                    check_field("size_mean", exp_e.size_mean, act.size_mean);
                    check_field("failure_total", exp_e.failure_total, act.failure_total);
                    check_field("failure_bytes_sum", exp_e.failure_bytes_sum,
                                act.failure_bytes_sum);
                    check_field("async_total", exp_e.async_total, act.async_total);
                end
            end
            if (hold_off_req > 0) begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!ready_quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    task automatic test_directed();
        // first sample of an entry at zero, then the extremes
        send_record(6'd0, OP_CREATE, 1, 0, 0, 32'd0, 32'd0, 32'd0, 1);
        send_record(6'd0, OP_CREATE, 1, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1);
        send_record(6'd0, OP_CREATE, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1);
        send_record(6'd0, OP_CREATE, 1, 0, 1, 32'd7, 32'd3, 32'hFFFF_FFFF, 1);
        // aborted only, both flags, neither flag
        send_record(6'd0, OP_CREATE, 0, 1, 0, 32'd9, 32'd9, 32'hFFFF_FFFF, 1);
        send_record(6'd0, OP_CREATE, 0, 1, 1, 32'd1, 32'd1, 32'hFFFF_FFFF, 1);
        send_record(6'd0, OP_CREATE, 1, 1, 0, 32'd100, 32'd200, 32'd300, 1);
        send_record(6'd0, OP_CREATE, 0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1);
        // entry with no completed sample
        send_record(6'd63, OP_CLOSE, 0, 1, 1, 32'hFFFF_FFFF, 32'h1234, 32'hDEAD_BEEF, 1);
        send_record(6'd63, OP_CLOSE, 0, 0, 0, 32'd0, 32'd0, 32'd0, 1);
        // every class but OP_CREATE once
        send_record(6'd21, OP_CONNECT, 1, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 1);
        send_record(6'd42, OP_ACCEPT, 1, 0, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 1);
        send_record(6'd1, OP_IOCTL, 0, 1, 0, 32'd0, 32'd0, 32'h8000_0000, 1);
        send_record(6'd2, OP_FSCTL, 1, 0, 0, 32'd50, 32'd60, 32'd70, 1);
        send_record(6'd3, OP_READ, 1, 0, 1, 32'd4096, 32'd512, 32'd1, 1);
        send_record(6'd4, OP_WRITE, 1, 0, 0, 32'd1, 32'd4096, 32'd1, 1);
        send_record(6'd63, OP_CLOSE, 1, 0, 0, 32'd8, 32'd8, 32'd8, 1);
        // classes out of range are dropped, then one in-range record
        send_record(6'd5, OP_NONE, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1);
        send_record(6'd5, 4'd9, 1, 0, 1, 32'd3, 32'd3, 32'd3, 1);
        send_record(6'd5, OP_BAD_HI, 0, 1, 0, 32'd3, 32'd3, 32'd3, 1);
        send_record(6'd5, OP_CREATE, 1, 0, 0, 32'd11, 32'd12, 32'd13, 1);
    endtask

    task automatic send_random(bit use_gaps);
        logic [OBJ_W-1:0] obj;
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] vals [3];
        int               k;
        // mostly objects 0 to 3 so the running stats build up
        obj = ($urandom_range(0, 99) < 70) ? OBJ_W'($urandom_range(0, 3))
                                           : OBJ_W'($urandom);
        if ($urandom_range(0, 99) < 5) op = ($urandom_range(0, 1) == 0) ? OP_NONE
                                            : OP_W'($urandom_range(9, 15));
        else op = OP_W'($urandom_range(1, N_OP));
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 4))
                0:       vals[k] = $urandom;
                1:       vals[k] = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
                2:       vals[k] = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                default: vals[k] = $urandom_range(0, 5000);
            endcase
        end
        send_record(obj, op, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 30,
                    $urandom_range(0, 1), vals[0], vals[1], vals[2], use_gaps);
    endtask

    task automatic test_random_traffic();
        int i;
        for (i = 0; i < 1300; i++) begin
            // stretches without idling on either side
            if (i == 600) ready_quiet = 1'b1;
            if (i == 800) ready_quiet = 1'b0;
            send_random(!(i >= 600 && i < 800));
        end
    endtask

    task automatic test_output_hold_off();
        int i;
        hold_off_req = 600;
        for (i = 0; i < 500; i++) send_random($urandom_range(0, 3) == 0);
    endtask

    initial begin
        int i;
        mismatches    = 0;
        reported      = 0;
        ready_quiet   = 1'b0;
        hold_off_req  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (i = 0; i < DEPTH; i++) begin
            tbl_req[i] = '0;  tbl_done[i] = '0;  tbl_dsum[i] = '0;
            tbl_lmin[i] = '0; tbl_lmax[i] = '0;  tbl_lmean[i] = '0;
            tbl_smin[i] = '0; tbl_smax[i] = '0;  tbl_smean[i] = '0;
            tbl_fail[i] = '0; tbl_fsum[i] = '0;  tbl_async[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_output_hold_off();
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_entries.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #24000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
